>>> rtl/core/vector_angle_unit_assert.svh
// Assertion macros for the vector angle unit.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef VECTOR_ANGLE_UNIT_ASSERT_SVH
`define VECTOR_ANGLE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define VAU_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vector_angle_unit: assertion failed");

// Next-cycle implication, disabled while in reset.
`define VAU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("vector_angle_unit: assertion failed");

`endif

>>> rtl/core/vau_pkg.sv
// Shared types, widths and tables for the vector angle unit.
// No dependencies.
package vau_pkg;

  localparam int COMPONENT_BITS_DEF  = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 16;
  localparam int CORDIC_STEPS        = 31;
  localparam int SQRT_STEPS          = 32;
  localparam int C2_W                = 62;
  localparam int XM_W                = 31;
  localparam int ROOT_W              = 63;
  localparam int CORD_W              = 34;
  localparam int Z_W                 = 33;

  localparam logic signed [Z_W-1:0] PI_Q30      = 33'sd3373259426;
  localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 33'sd1686629713;

  typedef struct packed {
    logic valid;
    logic zero;
    logic dot_neg;
    logic neg_cross;
    logic three;
  } side_t;

  typedef struct packed {
    logic [C2_W-1:0] c2;
    logic [XM_W-1:0] xm;
  } norm_t;

  function automatic logic [29:0] atan_q30(input int unsigned idx);
    logic [29:0] r;
    case (idx)
      0:  r = 30'h3243F6A8;  1:  r = 30'h1DAC6705;  2:  r = 30'h0FADBAFC;
      3:  r = 30'h07F56EA6;  4:  r = 30'h03FEAB76;  5:  r = 30'h01FFD55B;
      6:  r = 30'h00FFFAAA;  7:  r = 30'h007FFF55;  8:  r = 30'h003FFFEA;
      9:  r = 30'h001FFFFD;  10: r = 30'h000FFFFF;  11: r = 30'h0007FFFF;
      12: r = 30'h0003FFFF;  13: r = 30'h0001FFFF;  14: r = 30'h0000FFFF;
      15: r = 30'h00007FFF;  16: r = 30'h00003FFF;  17: r = 30'h00001FFF;
      18: r = 30'h00000FFF;  19: r = 30'h000007FF;  20: r = 30'h000003FF;
      21: r = 30'h000001FF;  22: r = 30'h000000FF;  23: r = 30'h0000007F;
      24: r = 30'h0000003F;  25: r = 30'h0000001F;  26: r = 30'h0000000F;
      27: r = 30'h00000008;  28: r = 30'h00000004;  29: r = 30'h00000002;
      30: r = 30'h00000001;
      default: r = 30'h0;
    endcase
    return r;
  endfunction

  // Shift right, rounding toward zero.
  function automatic logic signed [CORD_W-1:0] trunc_shr(input logic signed [CORD_W-1:0] v,
                                                         input int unsigned s);
    logic signed [CORD_W-1:0] mag;
    mag = -v;
    return v[CORD_W-1] ? -(mag >>> s) : (v >>> s);
  endfunction

endpackage

>>> rtl/core/vau_front.sv
// Front stages: narrowing, products, sums, squares and coarse scaling.
// Depends on vau_pkg.
module vau_front import vau_pkg::*; #(
  parameter int CB = COMPONENT_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 in_valid_i,
  input  logic                 three_dims_i,
  input  logic signed [CB-1:0] first_x_i,
  input  logic signed [CB-1:0] first_y_i,
  input  logic signed [CB-1:0] first_z_i,
  input  logic signed [CB-1:0] second_x_i,
  input  logic signed [CB-1:0] second_y_i,
  input  logic signed [CB-1:0] second_z_i,
  output side_t                side_o,
  output norm_t                norm_o
);

  localparam int CW   = (CB > 16) ? CB : 16;
  localparam int KMAX = CW - 16;

  function automatic logic fits16(input logic signed [CW-1:0] v);
    return (v <= 32767) && (v >= -32768);
  endfunction

  // Floor-shift the whole vector by the smallest amount that fits 16 bits.
  function automatic logic [47:0] narrow3(input logic signed [CW-1:0] c0,
                                          input logic signed [CW-1:0] c1,
                                          input logic signed [CW-1:0] c2);
    logic [47:0] res;
    logic signed [CW-1:0] s0, s1, s2;
    res = '0;
    for (int k = KMAX; k >= 0; k--) begin
      s0 = c0 >>> k;
      s1 = c1 >>> k;
      s2 = c2 >>> k;
      if (fits16(s0) && fits16(s1) && fits16(s2)) begin
        res = {s0[15:0], s1[15:0], s2[15:0]};
      end
    end
    return res;
  endfunction

  logic signed [CW-1:0] ax, ay, az, bx, by, bz;
  logic                 zero_d;
  logic [47:0]          na, nb;

  assign ax = CW'(first_x_i);
  assign ay = CW'(first_y_i);
  assign az = three_dims_i ? CW'(first_z_i) : '0;
  assign bx = CW'(second_x_i);
  assign by = CW'(second_y_i);
  assign bz = three_dims_i ? CW'(second_z_i) : '0;
  assign zero_d = (ax == '0 && ay == '0 && az == '0) || (bx == '0 && by == '0 && bz == '0);
  assign na = narrow3(ax, ay, az);
  assign nb = narrow3(bx, by, bz);

  side_t s1_q, s2_q, s3_q, s4_q, s5_q;
  logic signed [15:0] a_q [3];
  logic signed [15:0] b_q [3];
  logic signed [31:0] p_q [9];
  logic [31:0]        xm3_q, xm4_q;
  logic signed [32:0] cx_q, cy_q, cz_q;
  logic [62:0]        sq_q [3];
  norm_t              norm_q;

  logic signed [33:0] dot_d;
  logic signed [32:0] cx_d, cy_d, cz_d;
  logic signed [65:0] sqx, sqy, sqz;
  logic [63:0]        c2_d;
  logic               down;

  assign dot_d = 34'(p_q[0]) + 34'(p_q[1]) + 34'(p_q[2]);
  assign cz_d  = 33'(p_q[3]) - 33'(p_q[4]);
  assign cx_d  = 33'(p_q[5]) - 33'(p_q[6]);
  assign cy_d  = 33'(p_q[7]) - 33'(p_q[8]);
  assign sqx   = cx_q * cx_q;
  assign sqy   = cy_q * cy_q;
  assign sqz   = cz_q * cz_q;
  assign c2_d  = 64'(sq_q[0]) + 64'(sq_q[1]) + 64'(sq_q[2]);
  assign down  = (c2_d[63:62] != 2'b00) || xm4_q[31];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0; s2_q <= '0; s3_q <= '0; s4_q <= '0; s5_q <= '0;
    end else if (en_i) begin
      s1_q <= '{valid: in_valid_i, zero: zero_d, dot_neg: 1'b0, neg_cross: 1'b0,
                three: three_dims_i};
      s2_q <= s1_q;
      s3_q <= '{valid: s2_q.valid, zero: s2_q.zero, dot_neg: dot_d[33],
                neg_cross: cz_d[32], three: s2_q.three};
      s4_q <= s3_q;
      s5_q <= s4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q[0] <= na[47:32]; a_q[1] <= na[31:16]; a_q[2] <= na[15:0];
      b_q[0] <= nb[47:32]; b_q[1] <= nb[31:16]; b_q[2] <= nb[15:0];
      p_q[0] <= a_q[0] * b_q[0];
      p_q[1] <= a_q[1] * b_q[1];
      p_q[2] <= a_q[2] * b_q[2];
      p_q[3] <= a_q[0] * b_q[1];
      p_q[4] <= a_q[1] * b_q[0];
      p_q[5] <= a_q[1] * b_q[2];
      p_q[6] <= a_q[2] * b_q[1];
      p_q[7] <= a_q[2] * b_q[0];
      p_q[8] <= a_q[0] * b_q[2];
      xm3_q  <= dot_d[33] ? 32'(-dot_d) : 32'(dot_d);
      cx_q   <= cx_d;
      cy_q   <= cy_d;
      cz_q   <= cz_d;
      sq_q[0] <= sqx[62:0];
      sq_q[1] <= sqy[62:0];
      sq_q[2] <= sqz[62:0];
      xm4_q  <= xm3_q;
      norm_q.c2 <= down ? c2_d[63:2] : c2_d[61:0];
      norm_q.xm <= down ? xm4_q[31:1] : xm4_q[30:0];
    end
  end

  assign side_o = s5_q;
  assign norm_o = norm_q;

endmodule

>>> rtl/core/vau_norm_cell.sv
// One scaling cell: shift C by 2*SHIFT and X by SHIFT while both stay small.
// Depends on vau_pkg.
module vau_norm_cell import vau_pkg::*; #(
  parameter int SHIFT = 1
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  side_t side_i,
  input  norm_t norm_i,
  output side_t side_o,
  output norm_t norm_o
);

  localparam logic [C2_W-1:0] C2_LIM = C2_W'(1) << (60 - 2 * SHIFT);
  localparam logic [XM_W-1:0] XM_LIM = XM_W'(1) << (30 - SHIFT);

  side_t side_q;
  norm_t norm_q;
  logic  take;

  assign take = (norm_i.c2 < C2_LIM) && (norm_i.xm < XM_LIM);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else if (en_i) begin
      side_q <= side_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      norm_q.c2 <= take ? (norm_i.c2 << (2 * SHIFT)) : norm_i.c2;
      norm_q.xm <= take ? (norm_i.xm << SHIFT) : norm_i.xm;
    end
  end

  assign side_o = side_q;
  assign norm_o = norm_q;

endmodule

>>> rtl/core/vau_sqrt_cell.sv
// One digit of the integer square root, weight 4^STEP.
// Depends on vau_pkg.
module vau_sqrt_cell import vau_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  side_t             side_i,
  input  logic [C2_W-1:0]   v_i,
  input  logic [ROOT_W-1:0] r_i,
  input  logic [XM_W-1:0]   xm_i,
  output side_t             side_o,
  output logic [C2_W-1:0]   v_o,
  output logic [ROOT_W-1:0] r_o,
  output logic [XM_W-1:0]   xm_o
);

  localparam logic [ROOT_W-1:0] BIT = ROOT_W'(1) << (2 * STEP);

  side_t             side_q;
  logic [C2_W-1:0]   v_q;
  logic [ROOT_W-1:0] r_q;
  logic [XM_W-1:0]   xm_q;
  logic [63:0]       trial, diff;
  logic              hit;

  assign trial = 64'(r_i) + 64'(BIT);
  assign hit   = 64'(v_i) >= trial;
  assign diff  = 64'(v_i) - trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else if (en_i) begin
      side_q <= side_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q  <= hit ? diff[C2_W-1:0] : v_i;
      r_q  <= hit ? ((r_i >> 1) + BIT) : (r_i >> 1);
      xm_q <= xm_i;
    end
  end

  assign side_o = side_q;
  assign v_o    = v_q;
  assign r_o    = r_q;
  assign xm_o   = xm_q;

endmodule

>>> rtl/core/vau_cordic_cell.sv
// One CORDIC vectoring micro-rotation, shift STEP.
// Depends on vau_pkg.
module vau_cordic_cell import vau_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  side_t                    side_i,
  input  logic signed [CORD_W-1:0] x_i,
  input  logic signed [CORD_W-1:0] y_i,
  input  logic signed [Z_W-1:0]    z_i,
  output side_t                    side_o,
  output logic signed [CORD_W-1:0] x_o,
  output logic signed [CORD_W-1:0] y_o,
  output logic signed [Z_W-1:0]    z_o
);

  localparam logic signed [Z_W-1:0] ATAN = $signed({3'b000, atan_q30(STEP)});

  side_t                    side_q;
  logic signed [CORD_W-1:0] x_q, y_q, dx, dy;
  logic signed [Z_W-1:0]    z_q;

  assign dx = trunc_shr(y_i, STEP);
  assign dy = trunc_shr(x_i, STEP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else if (en_i) begin
      side_q <= side_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (!y_i[CORD_W-1]) begin
        x_q <= x_i + dx; y_q <= y_i - dy; z_q <= z_i + ATAN;
      end else begin
        x_q <= x_i - dx; y_q <= y_i + dy; z_q <= z_i - ATAN;
      end
    end
  end

  assign side_o = side_q;
  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;

endmodule

>>> rtl/core/vector_angle_unit.sv
// Vector angle unit: angle between two integer vectors, atan2(|a x b|, a.b), signed
// by the cross product for a 2D pair. Throughput one beat per cycle unless the
// output stalls, set by the pipeline of cells (32 square-root digits, 31 CORDIC
// steps). An output stall holds every stage, so the input stalls in the same cycle.
// Asynchronous active-low reset clears every stage valid bit; data need none.
module vector_angle_unit import vau_pkg::*; #(
  parameter int COMPONENT_BITS  = COMPONENT_BITS_DEF,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             three_dims_i,
  input  logic signed [COMPONENT_BITS-1:0] first_x_i,
  input  logic signed [COMPONENT_BITS-1:0] first_y_i,
  input  logic signed [COMPONENT_BITS-1:0] first_z_i,
  input  logic signed [COMPONENT_BITS-1:0] second_x_i,
  input  logic signed [COMPONENT_BITS-1:0] second_y_i,
  input  logic signed [COMPONENT_BITS-1:0] second_z_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [ANGLE_FRAC_BITS+2:0] angle_o,
  output logic                             zero_length_o
);

  `include "vector_angle_unit_assert.svh"

  localparam int AW = ANGLE_FRAC_BITS + 3;
  localparam int SH = 30 - ANGLE_FRAC_BITS;
  localparam logic signed [Z_W+1:0] RND = (Z_W+2)'(1) <<< (SH - 1);
  // Pi in the output format, the largest magnitude a result may carry.
  localparam logic signed [Z_W+1:0] PI_OUT = ((Z_W+2)'(PI_Q30) + RND) >>> SH;

  localparam int NORM_CELLS = 5;

  // One enable for the whole pipe: advance unless the result is held.
  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  side_t front_side;
  norm_t front_norm;

  vau_front #(.CB(COMPONENT_BITS)) u_front (
    .clk_i, .rst_ni, .en_i(en), .in_valid_i, .three_dims_i,
    .first_x_i, .first_y_i, .first_z_i, .second_x_i, .second_y_i, .second_z_i,
    .side_o(front_side), .norm_o(front_norm)
  );

  // Coarse-to-fine scaling: shifts 16, 8, 4, 2, 1.
  side_t nm_side [NORM_CELLS+1];
  norm_t nm_data [NORM_CELLS+1];
  assign nm_side[0] = front_side;
  assign nm_data[0] = front_norm;

  for (genvar g = 0; g < NORM_CELLS; g++) begin : g_norm
    vau_norm_cell #(.SHIFT(1 << (NORM_CELLS - 1 - g))) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .side_i(nm_side[g]), .norm_i(nm_data[g]),
      .side_o(nm_side[g+1]), .norm_o(nm_data[g+1])
    );
  end

  // Last step: one more shift unless C or X has already reached its upper limit.
  side_t fin_side_q;
  norm_t fin_norm_q;
  logic  fin_take;
  assign fin_take = (nm_data[NORM_CELLS].c2 < (C2_W'(1) << 60)) &&
                    (nm_data[NORM_CELLS].xm < (XM_W'(1) << 30));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_side_q <= '0;
    end else if (en) begin
      fin_side_q <= nm_side[NORM_CELLS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fin_norm_q.c2 <= fin_take ? (nm_data[NORM_CELLS].c2 << 2) : nm_data[NORM_CELLS].c2;
      fin_norm_q.xm <= fin_take ? (nm_data[NORM_CELLS].xm << 1) : nm_data[NORM_CELLS].xm;
    end
  end

  // Square root of C, one result bit per cell, most significant first.
  side_t             sq_side [SQRT_STEPS+1];
  logic [C2_W-1:0]   sq_v    [SQRT_STEPS+1];
  logic [ROOT_W-1:0] sq_r    [SQRT_STEPS+1];
  logic [XM_W-1:0]   sq_xm   [SQRT_STEPS+1];
  assign sq_side[0] = fin_side_q;
  assign sq_v[0]    = fin_norm_q.c2;
  assign sq_r[0]    = '0;
  assign sq_xm[0]   = fin_norm_q.xm;

  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
    vau_sqrt_cell #(.STEP(SQRT_STEPS - 1 - g)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .side_i(sq_side[g]), .v_i(sq_v[g]), .r_i(sq_r[g]), .xm_i(sq_xm[g]),
      .side_o(sq_side[g+1]), .v_o(sq_v[g+1]), .r_o(sq_r[g+1]), .xm_o(sq_xm[g+1])
    );
  end

  // CORDIC vectoring on (X, sqrt C): the angle gathers in z.
  side_t                    co_side [CORDIC_STEPS+1];
  logic signed [CORD_W-1:0] co_x    [CORDIC_STEPS+1];
  logic signed [CORD_W-1:0] co_y    [CORDIC_STEPS+1];
  logic signed [Z_W-1:0]    co_z    [CORDIC_STEPS+1];
  assign co_side[0] = sq_side[SQRT_STEPS];
  assign co_x[0]    = $signed({3'b000, sq_xm[SQRT_STEPS]});
  assign co_y[0]    = $signed({3'b000, sq_r[SQRT_STEPS][XM_W-1:0]});
  assign co_z[0]    = '0;

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
    vau_cordic_cell #(.STEP(g)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .side_i(co_side[g]), .x_i(co_x[g]), .y_i(co_y[g]), .z_i(co_z[g]),
      .side_o(co_side[g+1]), .x_o(co_x[g+1]), .y_o(co_y[g+1]), .z_o(co_z[g+1])
    );
  end

  // Result stage: clamp to [0, pi/2], fold for an obtuse angle, round, sign or zero.
  logic signed [Z_W-1:0]   z_end, z_clamp, z_fold;
  logic signed [Z_W+1:0]   z_round;
  logic signed [AW-1:0]    angle_d;
  side_t                   end_side, out_side_q;
  logic signed [AW-1:0]    angle_q;

  assign z_end    = co_z[CORDIC_STEPS];
  assign end_side = co_side[CORDIC_STEPS];

  always_comb begin
    if (z_end[Z_W-1]) begin
      z_clamp = '0;
    end else if (z_end > HALF_PI_Q30) begin
      z_clamp = HALF_PI_Q30;
    end else begin
      z_clamp = z_end;
    end
    z_fold  = end_side.dot_neg ? (PI_Q30 - z_clamp) : z_clamp;
    z_round = ((Z_W+2)'(z_fold) + RND) >>> SH;
    if (end_side.zero) begin
      angle_d = '0;
    end else if (!end_side.three && end_side.neg_cross) begin
      angle_d = -z_round[AW-1:0];
    end else begin
      angle_d = z_round[AW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_side_q <= '0;
    end else if (en) begin
      out_side_q <= end_side;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      angle_q <= angle_d;
    end
  end

  assign out_valid_o   = out_side_q.valid;
  assign angle_o       = angle_q;
  assign zero_length_o = out_side_q.zero;

  // A zero-length pair always reports a zero angle.
  `VAU_ASSERT_NOW(a_zero_angle, out_valid_o && zero_length_o, angle_o == '0)
  // A 3D angle is never negative.
  `VAU_ASSERT_NOW(a_three_unsigned, out_valid_o && out_side_q.three, !angle_o[AW-1])
  // Every angle lies within plus or minus pi.
  `VAU_ASSERT_NOW(a_angle_range, out_valid_o,
                  ((Z_W+2)'(angle_o) <= PI_OUT) && ((Z_W+2)'(angle_o) >= -PI_OUT))

endmodule
